@@ hw/rtl/gtg_pkg.sv @@
// shared types, widths and constants of the go-to-goal controller
package gtg_pkg;

    // offset, square and root widths
    localparam int DW    = 17;
    localparam int SQW   = 35;
    localparam int SQ_STEPS = 17;

    // rotation datapath widths
    localparam int XW    = 41;
    localparam int ZW    = 34;
    localparam int ERRW  = 18;

    localparam logic signed [ZW-1:0] HALF_PI_S30 = 34'sd1686629713;

    // register indexes
    typedef enum logic [7:0] {
        REG_TARGET_X  = 8'd0,
        REG_TARGET_Y  = 8'd1,
        REG_GAIN      = 8'd2,
        REG_MAX_SPEED = 8'd3,
        REG_ARRIVE    = 8'd4,
        REG_TURN      = 8'd5
    } reg_idx_t;

    // payload of one root / rotation step
    typedef struct packed {
        logic [SQW-1:0]        rem;
        logic [SQW-1:0]        root;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic signed [15:0]    heading;
    } pipe_t;

    // arctangent table at scale 2^30, truncated
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = 34'sh3243F6A8;
            1:  r = 34'sh1DAC6705;
            2:  r = 34'sh0FADBAFC;
            3:  r = 34'sh07F56EA6;
            4:  r = 34'sh03FEAB76;
            5:  r = 34'sh01FFD55B;
            6:  r = 34'sh00FFFAAA;
            7:  r = 34'sh007FFF55;
            8:  r = 34'sh003FFFEA;
            9:  r = 34'sh001FFFFD;
            10: r = 34'sh000FFFFF;
            11: r = 34'sh0007FFFF;
            12: r = 34'sh0003FFFF;
            13: r = 34'sh0001FFFF;
            14: r = 34'sh0000FFFF;
            15: r = 34'sh00007FFF;
            16: r = 34'sh00003FFF;
            17: r = 34'sh00001FFF;
            18: r = 34'sh00000FFF;
            19: r = 34'sh000007FF;
            20: r = 34'sh000003FF;
            21: r = 34'sh000001FF;
            22: r = 34'sh000000FF;
            23: r = 34'sh0000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/gtg_step.sv @@
// one pipeline stage: an optional square root digit and an optional vectoring rotation step
module gtg_step
    import gtg_pkg::*;
#(
    parameter int SQ_ON   = 1,
    parameter int SQ_EXP  = 0,
    parameter int ROT_ON  = 1,
    parameter int ROT_IDX = 0
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  pipe_t in_data,
    output logic  out_valid,
    output pipe_t out_data
);

    pipe_t data_next;
    pipe_t data_reg;
    logic  valid_reg;

    // root digit and rotation
    always_comb
    begin
        logic [SQW-1:0]       bit_val;
        logic [SQW-1:0]       trial;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        data_next = in_data;
        bit_val   = SQW'(1) << SQ_EXP;
        trial     = in_data.root + bit_val;
        xs        = in_data.x >>> ROT_IDX;
        ys        = in_data.y >>> ROT_IDX;
        if (SQ_ON != 0)
        begin
            if (in_data.rem >= trial)
            begin
                data_next.rem  = in_data.rem - trial;
                data_next.root = (in_data.root >> 1) + bit_val;
            end
            else
            begin
                data_next.root = in_data.root >> 1;
            end
        end
        if (ROT_ON != 0)
        begin
            if (!in_data.y[XW-1])
            begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + atan_entry(ROT_IDX);
            end
            else
            begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - atan_entry(ROT_IDX);
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/go_to_goal_controller_core.sv @@
// go-to-goal controller top level
//
// Takes one pose item per cycle on s_axis unless the receiver stalls, and
// returns one command item per pose on the m_axis channel, in order.
// Configuration writes come in on the cfg channel (always ready) and must
// only be made while no item is in flight.
// Pipeline: 3 input stages, max(17, CORDIC_STAGES) root/rotation stages,
// then 2 decision stages.
// Throughput: one item per cycle while the receiver does not stall; the
// square root runs one digit per stage and the arctangent one rotation
// per stage, all in parallel.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module go_to_goal_controller_core
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    // pos_x [15:0], pos_y [31:16], heading [47:32]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // linear_speed [14:0], turn_rate [30:15], zero [31]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int L = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;

    logic signed [15:0] target_x_reg, target_y_reg;
    logic [15:0]        gain_reg;
    logic [14:0]        max_speed_reg, arrive_reg, turn_reg;
    logic               en;

    assign cfg_ready = 1'b1;
    assign en        = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= 16'sd1024;
            target_y_reg  <= 16'sd1024;
            gain_reg      <= 16'd4096;
            max_speed_reg <= 15'd1536;
            arrive_reg    <= 15'd102;
            turn_reg      <= 15'd819;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_X:  target_x_reg  <= cfg_data;
                REG_TARGET_Y:  target_y_reg  <= cfg_data;
                REG_GAIN:      gain_reg      <= cfg_data;
                REG_MAX_SPEED: max_speed_reg <= cfg_data[14:0];
                REG_ARRIVE:    arrive_reg    <= cfg_data[14:0];
                REG_TURN:      turn_reg      <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // valid bits of the front stages and the decision stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [15:0]   hd1_reg, hd2_reg;
    logic signed [33:0]   sqx_reg, sqy_reg;
    logic signed [XW-1:0] x2_reg, y2_reg;
    logic signed [ZW-1:0] z2_reg;
    pipe_t                p0_reg;

    logic signed [XW-1:0] x0, y0, x2_next, y2_next;
    logic signed [ZW-1:0] z2_next;

    // pre-rotation by a quarter turn when the offset points backward
    always_comb
    begin
        x0 = XW'(dx_reg) <<< 20;
        y0 = XW'(dy_reg) <<< 20;
        x2_next = x0;
        y2_next = y0;
        z2_next = '0;
        if (x0[XW-1])
        begin
            if (!y0[XW-1])
            begin
                x2_next = y0;
                y2_next = -x0;
                z2_next = HALF_PI_S30;
            end
            else
            begin
                x2_next = -y0;
                y2_next = x0;
                z2_next = -HALF_PI_S30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // offset, squares, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= DW'(target_x_reg) - DW'($signed(s_axis_tdata[15:0]));
            dy_reg  <= DW'(target_y_reg) - DW'($signed(s_axis_tdata[31:16]));
            hd1_reg <= $signed(s_axis_tdata[47:32]);
            sqx_reg <= 34'(dx_reg) * 34'(dx_reg);
            sqy_reg <= 34'(dy_reg) * 34'(dy_reg);
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
            z2_reg  <= z2_next;
            hd2_reg <= hd1_reg;
            p0_reg.rem     <= SQW'($unsigned(sqx_reg)) + SQW'($unsigned(sqy_reg));
            p0_reg.root    <= '0;
            p0_reg.x       <= x2_reg;
            p0_reg.y       <= y2_reg;
            p0_reg.z       <= z2_reg;
            p0_reg.heading <= hd2_reg;
        end
    end

    // root and rotation stages
    pipe_t pd [0:L];
    logic  pv [0:L];

    assign pd[0] = p0_reg;
    assign pv[0] = v3_reg;

    for (genvar j = 0; j < L; j++)
    begin : g_step
        gtg_step #(
            .SQ_ON   ((j < SQ_STEPS) ? 1 : 0),
            .SQ_EXP  ((j < SQ_STEPS) ? 2 * (SQ_STEPS - 1 - j) : 0),
            .ROT_ON  ((j < CORDIC_STAGES) ? 1 : 0),
            .ROT_IDX ((j < CORDIC_STAGES) ? j : 0)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (pv[j]),
            .in_data   (pd[j]),
            .out_valid (pv[j+1]),
            .out_data  (pd[j+1])
        );
    end

    // decision stage one: arrival, heading error, raw speed
    logic [DW-1:0]           goal_dist;
    logic signed [ZW-1:0]    z_round;
    logic signed [ERRW-1:0]  bearing;
    logic                    arrived_reg;
    logic signed [ERRW-1:0]  err_reg;
    logic [32:0]             prod_reg;

    assign goal_dist = pd[L].root[DW-1:0];
    assign z_round   = (pd[L].z + ZW'(1 << 17)) >>> 18;
    assign bearing   = z_round[ERRW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arrived_reg <= goal_dist <= DW'(arrive_reg);
            err_reg     <= bearing - ERRW'(pd[L].heading);
            prod_reg    <= 33'(gain_reg) * 33'(goal_dist);
        end
    end

    // decision stage two: output item
    logic [ERRW-1:0]   mag;
    logic [20:0]       spd_raw;
    logic [14:0]       speed_next;
    logic signed [15:0] rate_next;
    logic [14:0]       speed_reg;
    logic signed [15:0] rate_reg;

    always_comb
    begin
        mag     = err_reg[ERRW-1] ? ERRW'(-err_reg) : ERRW'(err_reg);
        spd_raw = prod_reg[32:12];
        speed_next = '0;
        rate_next  = '0;
        if (!arrived_reg)
        begin
            if (mag > ERRW'(turn_reg))
            begin
                if (err_reg > 18'sd32767)
                    rate_next = 16'sd32767;
                else if (err_reg < -18'sd32768)
                    rate_next = -16'sd32768;
                else
                    rate_next = err_reg[15:0];
            end
            else if (spd_raw > 21'(max_speed_reg))
                speed_next = max_speed_reg;
            else
                speed_next = spd_raw[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= pv[L];
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_reg <= speed_next;
            rate_reg  <= rate_next;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {1'b0, rate_reg, speed_reg};

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the go-to-goal controller core
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gtg_pkg::*;

    localparam int STAGES      = 16;
    localparam int SETTLE      = 30;
    localparam logic [7:0] BAD_IDX = 8'd200;

    typedef enum logic [1:0] {K_POSE, K_CFG, K_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [47:0] pose;
        logic [7:0]  idx;
        logic [15:0] val;
    } job_t;

    typedef struct {
        logic [14:0] speed;
        logic [15:0] rate;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    job_t job_q[$];
    cmd_t cmd_q[$];

    // shadow of the register file
    logic signed [15:0] goal_x, goal_y;
    logic [15:0]        gain;
    logic [14:0]        speed_cap, stop_dist, turn_lim;

    int  errors, n_poses, n_cmds, n_cfg, n_stop, n_turn, n_drive, n_sat;
    int  quiet, gap, stall, hold;
    bit  hold_done;

    longint atan_tab [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    go_to_goal_controller_core #(.CORDIC_STAGES(STAGES)) dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring rotation, angle at 2^30, rounded to Q3.12
    function automatic longint bearing(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        x = dx * 1048576;
        y = dy * 1048576;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_S30;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_S30;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_tab[i];
            end
        end
        return (z + (64'sd1 << 17)) >>> 18;
    endfunction

    // expected command for one pose
    function automatic cmd_t steer(logic [47:0] p);
        longint dx, dy, err, mag;
        longint unsigned goal_dist, spd;
        cmd_t c;
        dx = longint'(goal_x) - longint'($signed(p[15:0]));
        dy = longint'(goal_y) - longint'($signed(p[31:16]));
        goal_dist = int_sqrt(longint'(dx * dx + dy * dy));
        c.speed = '0;
        c.rate = '0;
        if (goal_dist <= stop_dist)
            n_stop++;
        else
        begin
            err = bearing(dx, dy) - longint'($signed(p[47:32]));
            mag = err < 0 ? -err : err;
            if (mag > turn_lim)
            begin
                n_turn++;
                if (err > 32767 || err < -32768)
                    n_sat++;
                if (err > 32767)
                    err = 32767;
                if (err < -32768)
                    err = -32768;
                c.rate = err[15:0];
            end
            else
            begin
                n_drive++;
                spd = (longint'(gain) * goal_dist) >> 12;
                if (spd > speed_cap)
                begin
                    spd = speed_cap;
                    n_sat++;
                end
                c.speed = spd[14:0];
            end
        end
        return c;
    endfunction

    function automatic void add_pose(logic [15:0] px, logic [15:0] py, logic [15:0] hd);
        job_t j;
        j.kind = K_POSE;
        j.pose = {hd, py, px};
        j.idx = '0;
        j.val = '0;
        job_q.push_back(j);
    endfunction

    function automatic void add_cfg(logic [7:0] idx, logic [15:0] val);
        job_t j;
        j.kind = K_CFG;
        j.pose = '0;
        j.idx = idx;
        j.val = val;
        job_q.push_back(j);
    endfunction

    function automatic void add_drain();
        job_t j;
        j.kind = K_DRAIN;
        j.pose = '0;
        j.idx = '0;
        j.val = '0;
        job_q.push_back(j);
    endfunction

    // driver: poses and register writes from the job queue
    always @(posedge clk or negedge rst_n)
    begin
        logic        nv, ncv;
        logic [47:0] nd;
        logic [7:0]  ni;
        logic [15:0] ncd;
        bit          holding;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            cfg_valid     <= 1'b0;
            cfg_index     <= '0;
            cfg_data      <= '0;
            goal_x = 16'sd1024;
            goal_y = 16'sd1024;
            gain = 16'd4096;
            speed_cap = 15'd1536;
            stop_dist = 15'd102;
            turn_lim = 15'd819;
            quiet = 0;
            gap = 0;
        end
        else
        begin
            nv = s_axis_tvalid;
            nd = s_axis_tdata;
            ncv = cfg_valid;
            ni = cfg_index;
            ncd = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd_q.push_back(steer(s_axis_tdata));
                n_poses++;
                nv = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_X:  goal_x = cfg_data;
                    REG_TARGET_Y:  goal_y = cfg_data;
                    REG_GAIN:      gain = cfg_data;
                    REG_MAX_SPEED: speed_cap = cfg_data[14:0];
                    REG_ARRIVE:    stop_dist = cfg_data[14:0];
                    REG_TURN:      turn_lim = cfg_data[14:0];
                    default: ;
                endcase
                n_cfg++;
                ncv = 1'b0;
            end
            holding = nv || ncv;
            if (cmd_q.size() == 0 && !nv)
                quiet++;
            else
                quiet = 0;
            if (!holding)
            begin
                if (gap > 0)
                    gap--;
                else if (job_q.size() > 0)
                begin
                    case (job_q[0].kind)
                        K_POSE:
                        begin
                            nv = 1'b1;
                            nd = job_q[0].pose;
                            void'(job_q.pop_front());
                            if (job_q.size() > 60 && hold == 0 && $urandom_range(0, 9) == 0)
                                gap = $urandom_range(1, 19);
                        end
                        K_CFG:
                            if (quiet >= SETTLE)
                            begin
                                ncv = 1'b1;
                                ni = job_q[0].idx;
                                ncd = job_q[0].val;
                                void'(job_q.pop_front());
                            end
                        default:
                            if (quiet >= SETTLE)
                                void'(job_q.pop_front());
                    endcase
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            cfg_valid     <= ncv;
            cfg_index     <= ni;
            cfg_data      <= ncd;
        end
    end

    // monitor: receiver stalls and result checking
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t e;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall = 0;
            hold = 0;
            hold_done = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_cmds++;
                if (cmd_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected command, actual %h", $realtime, m_axis_tdata);
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (m_axis_tdata[14:0] !== e.speed)
                    begin
                        errors++;
                        $display("%0t: linear_speed expected %0d actual %0d",
                                 $realtime, e.speed, m_axis_tdata[14:0]);
                    end
                    if (m_axis_tdata[30:15] !== e.rate)
                    begin
                        errors++;
                        $display("%0t: turn_rate expected %0d actual %0d", $realtime,
                                 $signed(e.rate), $signed(m_axis_tdata[30:15]));
                    end
                    if (m_axis_tdata[31] !== 1'b0)
                    begin
                        errors++;
                        $display("%0t: pad bit expected 0 actual %b", $realtime,
                                 m_axis_tdata[31]);
                    end
                end
            end
            // one long hold-off so the pipeline backs up
            if (!hold_done && n_poses >= 200)
            begin
                hold_done = 1;
                hold = 150;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (job_q.size() > 60 && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] gx, gy, px, py, hd;
        longint b;
        errors = 0;
        n_poses = 0;
        n_cmds = 0;
        n_cfg = 0;
        n_stop = 0;
        n_turn = 0;
        n_drive = 0;
        n_sat = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_axis_tready = 1'b0;

        // directed poses at reset settings (goal at 1.0, 1.0)
        add_pose(16'd1024, 16'd1024, 16'd0);          // zero offset
        add_pose(16'd1074, 16'd1000, 16'd0);          // inside stop distance
        add_pose(16'd0, 16'd0, 16'd3217);             // driving, speed under the cap
        add_pose(16'd824, 16'd1024, 16'd0);           // driving slowly
        add_pose(16'd0, 16'd0, 16'h8000);             // turning left
        add_pose(16'd0, 16'd0, 16'h7FFF);             // turning right
        add_pose(16'd2048, 16'd0, 16'h8000);          // dx < 0, dy > 0, saturate
        add_pose(16'd2048, 16'd2048, 16'h7FFF);       // dx < 0, dy < 0, saturate
        add_pose(16'h8000, 16'h8000, 16'd0);
        add_pose(16'h7FFF, 16'h7FFF, 16'd0);
        add_pose(16'h8000, 16'h7FFF, 16'hFFFF);
        add_pose(16'h7FFF, 16'h8000, 16'd1);
        add_pose(16'd1024, 16'd0, 16'd6434);          // straight down the y axis
        add_pose(16'd2048, 16'd1024, 16'd12868);      // straight back along x
        add_drain();
        // extreme settings with an ignored write
        add_cfg(REG_TARGET_X, 16'h8000);
        add_cfg(REG_TARGET_Y, 16'h7FFF);
        add_cfg(REG_GAIN, 16'hFFFF);
        add_cfg(REG_MAX_SPEED, 16'h7FFF);
        add_cfg(REG_ARRIVE, 16'd0);
        add_cfg(REG_TURN, 16'h7FFF);
        add_cfg(BAD_IDX, 16'h0000);
        add_pose(16'h8000, 16'h7FFF, 16'd0);          // zero offset, zero threshold
        add_pose(16'h7FFF, 16'h8000, 16'd0);          // largest offset
        add_pose(16'h8001, 16'h7FFF, 16'd0);
        add_drain();

        // random phases, each under its own settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin gx = 16'h7FFF; gy = 16'h8000; end
                1: begin gx = 16'd0; gy = 16'd0; end
                default: begin gx = $urandom; gy = $urandom; end
            endcase
            add_cfg(REG_TARGET_X, gx);
            add_cfg(REG_TARGET_Y, gy);
            add_cfg(REG_GAIN, ph == 1 ? 16'd0 : 16'($urandom_range(0, 65535)));
            add_cfg(REG_MAX_SPEED, ph == 2 ? 16'd0 : 16'($urandom_range(0, 32767)));
            add_cfg(REG_ARRIVE, ph == 3 ? 16'h7FFF : 16'($urandom_range(0, 600)));
            add_cfg(REG_TURN, ph == 4 ? 16'd0 : 16'($urandom_range(0, 4000)));
            for (int k = 0; k < 100; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    px = $urandom;
                    py = $urandom;
                    hd = $urandom;
                end
                else
                begin
                    px = gx + 16'($signed($urandom_range(0, 4000)) - 2000);
                    py = gy + 16'($signed($urandom_range(0, 4000)) - 2000);
                    b = bearing(longint'($signed(gx)) - longint'($signed(px)),
                                longint'($signed(gy)) - longint'($signed(py)));
                    hd = 16'(b + $signed($urandom_range(0, 6000)) - 3000);
                end
                add_pose(px, py, hd);
            end
            // sender waits for the pipeline to empty after phase 2
            if (ph == 2)
                add_drain();
        end
        add_drain();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (job_q.size() == 0 && cmd_q.size() == 0 && !s_axis_tvalid && !cfg_valid);
        repeat (40) @(posedge clk);
        $display("covered %0d poses, %0d register writes: %0d stopped, %0d turning, %0d driving",
                 n_poses, n_cfg, n_stop, n_turn, n_drive);
        $display("%0d commands checked, %0d clipped at a limit", n_cmds, n_sat);
        if (errors == 0 && cmd_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
